### rtl/core/byte_write_burst_coalescer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte write burst coalescer
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_WRITE_BURST_COALESCER_DEFINES_SVH
`define BYTE_WRITE_BURST_COALESCER_DEFINES_SVH

// Same-cycle implication.
`define BWBC_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/bwbc_pkg.sv
// ----------------------------------------------------------------------------
// bwbc_pkg
// Types and constants shared by the burst coalescer front end, queue and
// back end.
// ----------------------------------------------------------------------------
package bwbc_pkg;

   localparam int MAX_BURST = 16;
   localparam int BURST_AW  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
   localparam int BURST_CW  = $clog2(MAX_BURST + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int IDX_W  = 30;
   localparam int ADDR_W = 32;
   localparam int WORD_W = 32;
   localparam int BYTE_W = 8;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_END   = 1'b1;

   // One closed word on its way to the burst buffer.
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] data;
      logic              flush;   // emit the burst after appending this word
   } word_entry_type;

endpackage

### rtl/core/bwbc_front.sv
// ----------------------------------------------------------------------------
// bwbc_front
// Merges byte writes into the pending word and closes it into the queue
// when a byte lands in another word or the stream ends.
// ----------------------------------------------------------------------------
module bwbc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [31:0]                req_byte_addr,
   input  logic [7:0]                 req_byte_data,
   output logic                       push_valid,
   input  logic                       push_ready,
   output bwbc_pkg::word_entry_type   push_data
);
   import bwbc_pkg::*;

   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [WORD_W-1:0] pend_word_ff, pend_word_in;

   logic              accept;
   logic [IDX_W-1:0]  req_idx;
   logic [4:0]        lane_base;
   logic              contiguous;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign req_idx    = req_byte_addr[ADDR_W-1:2];
   assign lane_base  = {~req_byte_addr[1:0], 3'b000};
   assign contiguous = ((pend_idx_ff + IDX_W'(1)) == req_idx);

   // Classify the transfer and decide whether the pending word closes
   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_idx_in     = pend_idx_ff;
      pend_word_in    = pend_word_ff;
      push_valid      = 1'b0;
      push_data.idx   = pend_idx_ff;
      push_data.data  = pend_word_ff;
      push_data.flush = 1'b0;
      if (accept) begin
         if (req_func == FUNC_END) begin
            if (pend_valid_ff) begin
               push_valid      = 1'b1;
               push_data.flush = 1'b1;
               pend_valid_in   = 1'b0;
            end
         end else if (pend_valid_ff && (req_idx == pend_idx_ff)) begin
            pend_word_in[lane_base +: BYTE_W] = req_byte_data;
         end else begin
            if (pend_valid_ff) begin
               push_valid      = 1'b1;
               push_data.flush = !contiguous;
            end
            pend_valid_in                     = 1'b1;
            pend_idx_in                       = req_idx;
            pend_word_in                      = '0;
            pend_word_in[lane_base +: BYTE_W] = req_byte_data;
         end
      end
   end

   // Hold the pending word
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_idx_ff  <= pend_idx_in;
      pend_word_ff <= pend_word_in;
   end

endmodule

### rtl/core/bwbc_fifo.sv
// ----------------------------------------------------------------------------
// bwbc_fifo
// Short queue of closed words between the front end and the back end.
// ----------------------------------------------------------------------------
module bwbc_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  bwbc_pkg::word_entry_type   push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output bwbc_pkg::word_entry_type   pop_data
);
   import bwbc_pkg::*;

   word_entry_type       slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/bwbc_back.sv
// ----------------------------------------------------------------------------
// bwbc_back
// Collects closed words into the burst buffer and plays each burst out as
// address/data transfers with first and last marks.
// ----------------------------------------------------------------------------
module bwbc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  bwbc_pkg::word_entry_type   pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_word_addr,
   output logic [31:0]                rsp_word_data,
   output logic                       rsp_burst_first,
   output logic                       rsp_burst_last
);
   import bwbc_pkg::*;

   typedef enum logic {
      ST_FILL,
      ST_EMIT
   } state_type;

   logic [WORD_W-1:0]   burst_mem [MAX_BURST];

   state_type           state_ff;
   logic [BURST_CW-1:0] count_ff;
   logic [BURST_CW-1:0] emit_k_ff;
   logic [IDX_W-1:0]    base_ff;
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [WORD_W-1:0]   rsp_data_ff;
   logic                rsp_first_ff;
   logic                rsp_last_ff;

   logic                do_pop;
   logic                load_out;
   logic [BURST_CW-1:0] count_next;
   logic                emit_last;

   assign pop_ready  = (state_ff == ST_FILL);
   assign do_pop     = pop_valid && pop_ready;
   assign load_out   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign count_next = count_ff + 1'b1;
   assign emit_last  = (BURST_CW'(emit_k_ff + 1'b1) == count_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_addr   = rsp_addr_ff;
   assign rsp_word_data   = rsp_data_ff;
   assign rsp_burst_first = rsp_first_ff;
   assign rsp_burst_last  = rsp_last_ff;

   // Burst buffer: write on append, registered read into the output stage
   always_ff @(posedge clock) begin
      if (do_pop) begin
         burst_mem[count_ff[BURST_AW-1:0]] <= pop_data.data;
      end
      if (load_out) begin
         rsp_data_ff <= burst_mem[emit_k_ff[BURST_AW-1:0]];
      end
   end

   // Append words, then play the burst out one transfer at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         emit_k_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_FILL: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (do_pop) begin
                  if (count_ff == '0) begin
                     base_ff <= pop_data.idx;
                  end
                  count_ff  <= count_next;
                  emit_k_ff <= '0;
                  if (pop_data.flush || (count_next == BURST_CW'(MAX_BURST))) begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (load_out) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_addr_ff  <= {base_ff + IDX_W'(emit_k_ff), 2'b00};
                  rsp_first_ff <= (emit_k_ff == '0);
                  rsp_last_ff  <= emit_last;
                  emit_k_ff    <= emit_k_ff + 1'b1;
                  if (emit_last) begin
                     count_ff <= '0;
                     state_ff <= ST_FILL;
                  end
               end
            end
            default: begin
               state_ff <= ST_FILL;
            end
         endcase
      end
   end

endmodule

### rtl/core/byte_write_burst_coalescer.sv
// Byte write burst coalescer. Each byte write is accepted while the internal
// word queue (four entries) has room; bytes of one word merge in place and cost
// nothing downstream. The back end appends one closed word per cycle while it
// is filling and, when a burst closes (gap in addresses, sixteen words, or end
// of stream), plays it out from the burst buffer at one transfer per cycle
// while the receiver is ready. During that playout the queue fills and the
// input stalls once it holds four closed words; the back end appends nothing
// while it plays a burst out, so the queue depth sets how much input rides
// through a playout.
// ----------------------------------------------------------------------------
// byte_write_burst_coalescer
// Top level: front end merge, word queue, and burst buffer with playout.
// ----------------------------------------------------------------------------
module byte_write_burst_coalescer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_byte_addr,
   input  logic [7:0]  req_byte_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_word_addr,
   output logic [31:0] rsp_word_data,
   output logic        rsp_burst_first,
   output logic        rsp_burst_last
);
   import bwbc_pkg::*;

   logic           push_valid, push_ready;
   word_entry_type push_data;
   logic           pop_valid, pop_ready;
   word_entry_type pop_data;

   bwbc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_byte_addr (req_byte_addr),
      .req_byte_data (req_byte_data),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   bwbc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bwbc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word_addr   (rsp_word_addr),
      .rsp_word_data   (rsp_word_data),
      .rsp_burst_first (rsp_burst_first),
      .rsp_burst_last  (rsp_burst_last)
   );

endmodule

### rtl/core/bwbc_checker.sv
// ----------------------------------------------------------------------------
// bwbc_checker
// Port-level checks on burst framing and address sequencing of results.
// ----------------------------------------------------------------------------
`include "byte_write_burst_coalescer_defines.svh"

module bwbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_func,
   input logic [31:0] req_byte_addr,
   input logic [7:0]  req_byte_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word_addr,
   input logic [31:0] rsp_word_data,
   input logic        rsp_burst_first,
   input logic        rsp_burst_last
);
   import bwbc_pkg::*;

   logic                rsp_xfer;
   logic                req_xfer;
   logic                prev_last_ff;
   logic [31:0]         prev_addr_ff;
   logic [BURST_CW-1:0] pos_ff;

   assign rsp_xfer = rsp_valid && rsp_ready;
   assign req_xfer = req_valid && req_ready;

   // Track the previous result transfer and the place within the burst
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_last_ff <= 1'b1;
         pos_ff       <= '0;
      end else if (rsp_xfer) begin
         prev_last_ff <= rsp_burst_last;
         pos_ff       <= rsp_burst_last ? '0 : BURST_CW'(pos_ff + 1'b1);
      end
      if (rsp_xfer) begin
         prev_addr_ff <= rsp_word_addr;
      end
   end

   `BWBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word_addr) && $stable(rsp_word_data) && $stable(rsp_burst_first) && $stable(rsp_burst_last), "result changed while stalled")
   `BWBC_ASSERT(a_first_after_last, rsp_xfer, rsp_burst_first == prev_last_ff, "burst first mark out of place")
   `BWBC_ASSERT(a_addr_step, rsp_xfer && !prev_last_ff, rsp_word_addr == prev_addr_ff + 32'd4, "burst address not contiguous")
   `BWBC_ASSERT(a_burst_limit, rsp_xfer && (pos_ff == BURST_CW'(MAX_BURST - 1)), rsp_burst_last, "burst longer than the buffer")
   `BWBC_ASSERT(a_req_byte_known, req_xfer && (req_func == FUNC_WRITE), !$isunknown(req_byte_data) && !$isunknown(req_byte_addr), "byte write with unknown payload")

endmodule

bind byte_write_burst_coalescer bwbc_checker u_bwbc_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the byte write burst coalescer. Drives byte writes and
// end-of-stream markers, predicts the merged words and burst markers, and
// compares every result transfer in order under random sender and receiver
// idling.
// ----------------------------------------------------------------------------

import bwbc_pkg::*;

// One expected result transfer.
typedef struct packed {
   logic [ADDR_W-1:0] addr;
   logic [WORD_W-1:0] data;
   logic              first;
   logic              last;
} word_beat_type;

// Tracks the open word and the burst buffer, and holds expected transfers.
class burst_scoreboard;
   bit                word_open;
   bit [IDX_W-1:0]    open_idx;
   bit [WORD_W-1:0]   open_word;
   bit [WORD_W-1:0]   burst_buf [MAX_BURST];
   bit [IDX_W-1:0]    burst_base;
   int                burst_fill;
   word_beat_type     expected_beats [$];
   int                errors;
   int                inputs_seen;
   int                beats_checked;
   int                bursts_seen;
   int                full_bursts;

   // Move the open word into the burst buffer.
   function void close_word();
      if (burst_fill == 0) begin
         burst_base = open_idx;
      end
      if (burst_fill < MAX_BURST) begin
         burst_buf[burst_fill] = open_word;
         burst_fill++;
      end
   endfunction

   // Queue the whole burst as expected transfers and empty the buffer.
   function void release_burst();
      word_beat_type  beat;
      bit [IDX_W-1:0] idx;
      bursts_seen++;
      if (burst_fill == MAX_BURST) begin
         full_bursts++;
      end
      for (int k = 0; k < burst_fill; k++) begin
         idx        = burst_base + k[IDX_W-1:0];
         beat.addr  = {idx, 2'b00};
         beat.data  = burst_buf[k];
         beat.first = (k == 0);
         beat.last  = (k + 1 == burst_fill);
         expected_beats.push_back(beat);
      end
      burst_fill = 0;
   endfunction

   // Open a new word holding only this byte.
   function void open_new(bit [IDX_W-1:0] idx, int lane, bit [BYTE_W-1:0] data);
      word_open = 1'b1;
      open_idx  = idx;
      open_word = '0;
      open_word[lane*8 +: 8] = data;
   endfunction

   function void note_input(logic func, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
      bit [IDX_W-1:0] idx;
      bit [IDX_W-1:0] next_idx;
      int             lane;
      idx      = addr[31:2];
      lane     = 3 - addr[1:0];
      next_idx = open_idx + 1'b1;
      inputs_seen++;
      if (func == FUNC_END) begin
         // End with nothing open leaves the state alone
         if (word_open) begin
            close_word();
            word_open = 1'b0;
            release_burst();
         end
      end else if (!word_open) begin
         open_new(idx, lane, data);
      end else if (idx == open_idx) begin
         // Replace one lane, keep the rest
         open_word[lane*8 +: 8] = data;
      end else begin
         close_word();
         if (next_idx != idx || burst_fill >= MAX_BURST) begin
            release_burst();
         end
         open_new(idx, lane, data);
      end
   endfunction

   function void check_beat(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data,
                            logic first, logic last);
      word_beat_type exp_beat;
      if (expected_beats.size() == 0) begin
         $error("result with none expected: word_addr %h word_data %h", addr, data);
         errors++;
      end else begin
         exp_beat = expected_beats.pop_front();
         beats_checked++;
         if (addr !== exp_beat.addr) begin
            $error("word_addr expected %h actual %h", exp_beat.addr, addr);
            errors++;
         end
         if (data !== exp_beat.data) begin
            $error("word_data expected %h actual %h", exp_beat.data, data);
            errors++;
         end
         if (first !== exp_beat.first) begin
            $error("burst_first expected %b actual %b", exp_beat.first, first);
            errors++;
         end
         if (last !== exp_beat.last) begin
            $error("burst_last expected %b actual %b", exp_beat.last, last);
            errors++;
         end
      end
   endfunction
endclass

module tb_top;

   localparam int RANDOM_ITEMS   = 430;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_WRITE;
   logic [31:0] req_byte_addr = '0;
   logic [7:0]  req_byte_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_word_addr;
   logic [31:0] rsp_word_data;
   logic        rsp_burst_first;
   logic        rsp_burst_last;

   burst_scoreboard sb;
   int send_idle_pct  = 15;
   int recv_stall_pct = 50;
   int items_driven   = 0;
   int quiet_cycles   = 0;

   byte_write_burst_coalescer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_byte_addr   (req_byte_addr),
      .req_byte_data   (req_byte_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word_addr   (rsp_word_addr),
      .rsp_word_data   (rsp_word_data),
      .rsp_burst_first (rsp_burst_first),
      .rsp_burst_last  (rsp_burst_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Randomly stall the result channel.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Check results, note accepted inputs, count quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_beat(rsp_word_addr, rsp_word_data, rsp_burst_first, rsp_burst_last);
         end
         if (req_valid && req_ready) begin
            sb.note_input(req_func, req_byte_addr, req_byte_data);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // End the run if nothing moves for too long.
   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Drive one item, starting and ending at a falling edge.
   task automatic send_item(input logic func, input logic [31:0] addr, input logic [7:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_byte_addr <= addr;
      req_byte_data <= data;
      do @(posedge clock); while (!req_ready);
      items_driven++;
      @(negedge clock);
   endtask

   // Write a run of consecutive words, one to four bytes each in random lanes.
   task automatic send_run(input int nwords, input logic [31:0] start_addr);
      logic [31:0] waddr;
      int          nbytes;
      waddr = {start_addr[31:2], 2'b00};
      for (int w = 0; w < nwords; w++) begin
         nbytes = $urandom_range(1, 4);
         for (int b = 0; b < nbytes; b++) begin
            send_item(FUNC_WRITE, waddr | $urandom_range(0, 3), 8'($urandom_range(0, 255)));
         end
         waddr = waddr + 32'd4;
      end
   endtask

   initial begin : stimulus
      int          random_start;
      int          choice;
      int          nwords;
      int          phase;
      logic [31:0] base;
      sb = new();

      // Hold reset, then release it at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: open word, lane merge and replace, contiguous words, gap
      send_item(FUNC_WRITE, 32'h0000_0000, 8'h00);
      send_item(FUNC_WRITE, 32'h0000_0003, 8'hff);
      send_item(FUNC_WRITE, 32'h0000_0001, 8'ha5);
      send_item(FUNC_WRITE, 32'h0000_0001, 8'h5a);
      send_item(FUNC_WRITE, 32'h0000_0004, 8'h11);
      send_item(FUNC_WRITE, 32'h0000_000a, 8'h22);
      send_item(FUNC_WRITE, 32'h0000_0100, 8'h33);
      // End with a word open, then end with nothing open
      send_item(FUNC_END, 32'hffff_ffff, 8'hff);
      send_item(FUNC_END, 32'h0000_0000, 8'h00);
      // Run across the top of the address space
      send_item(FUNC_WRITE, 32'hffff_fff8, 8'h80);
      send_item(FUNC_WRITE, 32'hffff_ffff, 8'h01);
      send_item(FUNC_WRITE, 32'hffff_fffe, 8'hc3);
      send_item(FUNC_WRITE, 32'h0000_0000, 8'hfe);
      send_item(FUNC_WRITE, 32'h0000_0002, 8'h7f);
      send_item(FUNC_END, 32'h5555_5555, 8'h55);
      // Single byte at the extremes, step backwards, then end
      send_item(FUNC_WRITE, 32'hffff_ffff, 8'hff);
      send_item(FUNC_WRITE, 32'hffff_fff0, 8'h00);
      send_item(FUNC_WRITE, 32'haaaa_aaaa, 8'haa);
      send_item(FUNC_END, 32'haaaa_aaaa, 8'haa);
      send_item(FUNC_END, 32'h5555_5555, 8'h55);

      // Random part: mostly contiguous runs, some noise
      random_start = items_driven;
      while (items_driven - random_start < RANDOM_ITEMS) begin
         phase = ((items_driven - random_start) * 3) / RANDOM_ITEMS;
         if (phase == 0) begin
            send_idle_pct  = 15;
            recv_stall_pct = 50;
         end else if (phase == 1) begin
            send_idle_pct  = 50;
            recv_stall_pct = 15;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         choice = $urandom_range(0, 99);
         if (items_driven == random_start) begin
            // Start with a run long enough to fill a burst
            send_run(17, $urandom);
         end else if (choice < 80) begin
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
               nwords = $urandom_range(1, 4);
            end else if (choice < 9) begin
               nwords = $urandom_range(5, 12);
            end else begin
               nwords = $urandom_range(15, 18);
            end
            if ($urandom_range(0, 9) == 0) begin
               base = 32'hffff_ffc0 | $urandom_range(0, 63);
            end else begin
               base = $urandom;
            end
            send_run(nwords, base);
            if ($urandom_range(0, 2) == 0) begin
               send_item(FUNC_END, $urandom, 8'($urandom_range(0, 255)));
            end
         end else if (choice < 90) begin
            send_item(FUNC_WRITE, $urandom, 8'($urandom_range(0, 255)));
         end else begin
            send_item(FUNC_END, $urandom, 8'($urandom_range(0, 255)));
         end
      end
      // Flush whatever is still open
      send_item(FUNC_END, $urandom, 8'($urandom_range(0, 255)));
      req_valid <= 1'b0;

      // Drain the results, then watch for strays
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input transfers and %0d result words in %0d bursts",
               sb.inputs_seen, sb.beats_checked, sb.bursts_seen);
      $display("%0d bursts closed at full length, %0d mismatches",
               sb.full_bursts, sb.errors);
      if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
